FILE: src/iucs_pkg.sv
package iucs_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned SumW   = 56;
  localparam int unsigned EnvW   = 47;
  localparam int unsigned CountW = 9;

  localparam logic [SumW-1:0] SUM_MAX = {SumW{1'b1}};
  localparam logic [EnvW-1:0] ENV_MAX = {EnvW{1'b1}};

  localparam logic [1:0] KIND_COMPUTE   = 2'd0;
  localparam logic [1:0] KIND_COMM      = 2'd1;
  localparam logic [1:0] KIND_DATA_MOVE = 2'd2;

  typedef struct packed {
    logic signed [TimeW-1:0] start_time;
    logic signed [TimeW-1:0] end_time;
    logic [1:0]              member_kind;
    logic                    has_member;
    logic                    last_member;
  } iucs_in_t;

  typedef struct packed {
    logic [CountW-1:0] interval_count;
    logic [SumW-1:0]   duration_total;
    logic [SumW-1:0]   compute_sum;
    logic [SumW-1:0]   communication_sum;
    logic [SumW-1:0]   data_move_sum;
    logic [SumW-1:0]   busy_length;
    logic [EnvW-1:0]   envelope;
  } iucs_out_t;

  typedef struct packed {
    logic signed [TimeW-1:0] start_time;
    logic signed [TimeW-1:0] end_time;
  } iucs_span_t;

  // One queued job for the back end: an interval to insert, a close, or both.
  typedef struct packed {
    logic             is_member;
    logic             is_close;
    iucs_span_t       span;
    logic [TimeW-1:0] duration;
    logic [1:0]       kind;
  } iucs_job_t;

  // Length hi - lo, clamped at zero.
  function automatic logic [TimeW-1:0] span_len(input logic signed [TimeW-1:0] lo,
                                                input logic signed [TimeW-1:0] hi);
    logic signed [TimeW:0] d;
    d = $signed({hi[TimeW-1], hi}) - $signed({lo[TimeW-1], lo});
    if (d > 0) begin
      return d[TimeW-1:0];
    end
    return '0;
  endfunction

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                              input logic [TimeW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {{(SumW-TimeW+1){1'b0}}, b};
    if (s > {1'b0, SUM_MAX}) begin
      return SUM_MAX;
    end
    return s[SumW-1:0];
  endfunction

endpackage

FILE: src/iucs_front.sv
module iucs_front import iucs_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  iucs_in_t  in_data_i,
  input  logic      q_full_i,
  output logic      full,
  output logic      enq_o,
  output iucs_job_t job_o
);

  localparam int unsigned CW = $clog2(MAX_MEMBERS + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;
  logic          take_member;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;

  // A member arriving at a full store is dropped outright.
  assign take_member = in_data_i.has_member && (cnt_q < CW'(MAX_MEMBERS));

  always_comb begin
    job_o.is_member       = take_member;
    job_o.is_close        = in_data_i.last_member;
    job_o.span.start_time = in_data_i.start_time;
    job_o.span.end_time   = in_data_i.end_time;
    job_o.duration        = span_len(in_data_i.start_time, in_data_i.end_time);
    job_o.kind            = in_data_i.member_kind;
  end

  assign enq_o = accept && (take_member || in_data_i.last_member);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (in_data_i.last_member) begin
        cnt_d = '0;
      end else if (take_member) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: src/iucs_fifo.sv
module iucs_fifo import iucs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      enq_i,
  input  iucs_job_t enq_data_i,
  output logic      full_o,
  input  logic      deq_i,
  output logic      nonempty_o,
  output iucs_job_t deq_data_o
);

  iucs_job_t   slot_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  fill_q;

  assign full_o     = (fill_q == 2'd2);
  assign nonempty_o = (fill_q != 2'd0);
  assign deq_data_o = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      slot_q[wptr_q] <= enq_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (enq_i) begin
        wptr_q <= !wptr_q;
      end
      if (deq_i) begin
        rptr_q <= !rptr_q;
      end
      fill_q <= fill_q + {1'b0, enq_i} - {1'b0, deq_i};
    end
  end

endmodule

FILE: src/iucs_back.sv
module iucs_back import iucs_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  iucs_job_t job_i,
  output logic      deq_o,
  input  logic      pop,
  output logic      empty,
  output iucs_out_t out_data_o
);

  localparam int unsigned CW = $clog2(MAX_MEMBERS + 1);
  localparam int unsigned AW = $clog2(MAX_MEMBERS);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_RD  = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_SW_RD   = 3'd3;
  localparam logic [2:0] ST_SW_PROC = 3'd4;
  localparam logic [2:0] ST_FIN     = 3'd5;

  iucs_span_t mem [MAX_MEMBERS];
  iucs_span_t rdata_q;
  logic       we;
  logic [AW-1:0] waddr, raddr;
  iucs_span_t wdata;

  logic [2:0]      st_q, st_d;
  logic [CW-1:0]   cnt_q, cnt_d, j_q, j_d, i_q, i_d;
  iucs_span_t      key_q, key_d;
  logic            close_q, close_d;
  logic [SumW-1:0] tot_q, tot_d, busy_q, busy_d;
  logic [SumW-1:0] ksum_q [3];
  logic [SumW-1:0] ksum_d [3];
  logic signed [TimeW-1:0] us_q, us_d, ue_q, ue_d, ee_q, ee_d, s0_q, s0_d;
  iucs_out_t       out_q, out_d;
  logic            out_full_q, out_full_d;

  logic            key_less;
  logic [SumW-1:0] busy_fin;
  logic signed [TimeW:0] env_diff;
  logic [EnvW-1:0] env_fin;

  assign empty      = !out_full_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign key_less = ($signed(key_q.start_time) < $signed(rdata_q.start_time)) ||
                    ((key_q.start_time == rdata_q.start_time) &&
                     ($signed(key_q.end_time) < $signed(rdata_q.end_time)));

  always_comb begin
    busy_fin = (cnt_q == '0) ? '0 : sat_add(busy_q, span_len(us_q, ue_q));
    env_diff = $signed({ee_q[TimeW-1], ee_q}) - $signed({s0_q[TimeW-1], s0_q});
    if (cnt_q == '0 || env_diff <= 0) begin
      env_fin = '0;
    end else if (env_diff > $signed({{(TimeW-EnvW+1){1'b0}}, ENV_MAX})) begin
      env_fin = ENV_MAX;
    end else begin
      env_fin = env_diff[EnvW-1:0];
    end
  end

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    j_d        = j_q;
    i_d        = i_q;
    key_d      = key_q;
    close_d    = close_q;
    tot_d      = tot_q;
    ksum_d     = ksum_q;
    busy_d     = busy_q;
    us_d       = us_q;
    ue_d       = ue_q;
    ee_d       = ee_q;
    s0_d       = s0_q;
    out_d      = out_q;
    out_full_d = out_full_q && !pop;
    deq_o      = 1'b0;
    we         = 1'b0;
    waddr      = j_q[AW-1:0];
    wdata      = key_q;
    raddr      = i_q[AW-1:0];

    case (st_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          deq_o   = 1'b1;
          close_d = job_i.is_close;
          if (job_i.is_member) begin
            tot_d = sat_add(tot_q, job_i.duration);
            if (job_i.kind == KIND_COMPUTE) begin
              ksum_d[0] = sat_add(ksum_q[0], job_i.duration);
            end else if (job_i.kind == KIND_COMM) begin
              ksum_d[1] = sat_add(ksum_q[1], job_i.duration);
            end else if (job_i.kind == KIND_DATA_MOVE) begin
              ksum_d[2] = sat_add(ksum_q[2], job_i.duration);
            end
            key_d = job_i.span;
            j_d   = cnt_q;
            cnt_d = cnt_q + CW'(1);
            st_d  = ST_INS_RD;
          end else if (cnt_q == '0) begin
            st_d = ST_FIN;
          end else begin
            i_d  = '0;
            st_d = ST_SW_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (j_q == '0) begin
          we = 1'b1;
          if (close_q) begin
            i_d  = '0;
            st_d = ST_SW_RD;
          end else begin
            st_d = ST_IDLE;
          end
        end else begin
          raddr = AW'(j_q - CW'(1));
          st_d  = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        we = 1'b1;
        if (key_less) begin
          wdata = rdata_q;
          j_d   = j_q - CW'(1);
          st_d  = ST_INS_RD;
        end else if (close_q) begin
          i_d  = '0;
          st_d = ST_SW_RD;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_SW_RD: begin
        st_d = ST_SW_PROC;
      end
      ST_SW_PROC: begin
        if (i_q == '0) begin
          us_d   = rdata_q.start_time;
          ue_d   = rdata_q.end_time;
          ee_d   = rdata_q.end_time;
          s0_d   = rdata_q.start_time;
          busy_d = '0;
        end else begin
          if ($signed(rdata_q.end_time) > ee_q) begin
            ee_d = rdata_q.end_time;
          end
          if ($signed(rdata_q.start_time) > ue_q) begin
            busy_d = sat_add(busy_q, span_len(us_q, ue_q));
            us_d   = rdata_q.start_time;
            ue_d   = rdata_q.end_time;
          end else if ($signed(rdata_q.end_time) > ue_q) begin
            ue_d = rdata_q.end_time;
          end
        end
        if (i_q == cnt_q - CW'(1)) begin
          st_d = ST_FIN;
        end else begin
          i_d  = i_q + CW'(1);
          st_d = ST_SW_RD;
        end
      end
      ST_FIN: begin
        if (!out_full_q || pop) begin
          out_d.interval_count    = CountW'(cnt_q);
          out_d.duration_total    = tot_q;
          out_d.compute_sum       = ksum_q[0];
          out_d.communication_sum = ksum_q[1];
          out_d.data_move_sum     = ksum_q[2];
          out_d.busy_length       = busy_fin;
          out_d.envelope          = env_fin;
          out_full_d = 1'b1;
          cnt_d      = '0;
          tot_d      = '0;
          ksum_d[0]  = '0;
          ksum_d[1]  = '0;
          ksum_d[2]  = '0;
          st_d       = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    busy_q  <= busy_d;
    us_q    <= us_d;
    ue_q    <= ue_d;
    ee_q    <= ee_d;
    s0_q    <= s0_d;
    out_q   <= out_d;
    j_q     <= j_d;
    i_q     <= i_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      cnt_q      <= '0;
      close_q    <= 1'b0;
      tot_q      <= '0;
      ksum_q[0]  <= '0;
      ksum_q[1]  <= '0;
      ksum_q[2]  <= '0;
      out_full_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      cnt_q      <= cnt_d;
      close_q    <= close_d;
      tot_q      <= tot_d;
      ksum_q     <= ksum_d;
      out_full_q <= out_full_d;
    end
  end

endmodule

FILE: src/interval_union_cost_summary_top.sv
// Busy-time summary of groups of timed intervals. Each input transaction may
// carry one interval (start, end, kind) and may close the group; a closing
// transaction yields one result with the member count, saturating duration
// sums in total and per kind, the length of the union of the intervals and
// the envelope from earliest start to latest end. A classifying front end
// accepts transactions into a two-entry queue; the back end keeps the
// intervals sorted in a memory of MAX_MEMBERS entries with one write port
// and one registered read port. A member is added to the sums and then
// moved into place by shifting up every stored interval that sorts after
// it, one compare and one write at a time; a close sweeps the stored
// intervals in order, merging overlaps, before the result is shown; a
// transaction that both adds and closes runs the sweep straight after its
// insertion. The last step of a close waits while the previous result
// has not yet been popped. Members beyond MAX_MEMBERS in one group are
// dropped. The finished result sits in an output register, so the next
// group's members keep flowing in while it waits to be popped.
module interval_union_cost_summary_top import iucs_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  iucs_in_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output iucs_out_t out_data_o
);

  // Transactions handed from the front end to the queue.
  logic      enq;
  iucs_job_t enq_job;
  logic      q_full;

  // Queue head towards the back end.
  logic      q_nonempty;
  logic      deq;
  iucs_job_t deq_job;

  // The front end works out the clamped duration and decides whether the
  // interval still fits in the store of the group.
  iucs_front #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .in_data_i(in_data_i),
    .q_full_i (q_full),
    .full     (full),
    .enq_o    (enq),
    .job_o    (enq_job)
  );

  iucs_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .enq_i     (enq),
    .enq_data_i(enq_job),
    .full_o    (q_full),
    .deq_i     (deq),
    .nonempty_o(q_nonempty),
    .deq_data_o(deq_job)
  );

  // The back end does the sums, the insertion sort and the merging sweep.
  iucs_back #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_nonempty),
    .job_i      (deq_job),
    .deq_o      (deq),
    .pop        (pop),
    .empty      (empty),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown during reset");

  a_no_enq_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(enq && q_full))
    else $error("transaction written into a full queue");

  a_no_deq_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq |-> q_nonempty)
    else $error("transaction taken from an empty queue");
`endif

endmodule
